[rtl/pmm_pkg.sv]
// Shared constants, operation codes and cell control type for the polynomial multiplier.
package pmm_pkg;

    // Number of taps and partial sums held in the cell chain.
    localparam int TERMS  = 32;
    localparam int COEF_W = 31;
    localparam int IDX_W  = $clog2(TERMS + 1);
    localparam int DEG_W  = 6;
    localparam int PROD_W = 2 * COEF_W + 1;
    localparam int RCNT_W = $clog2(PROD_W);

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_MUL   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_EMPTY = 2'd3;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic clear;
        logic shift;
        logic mul;
        logic red;
        logic commit;
    } pmm_cell_ctl_t;

endpackage

[rtl/pmm_cell.sv]
// One cell of the chain: a tap, a partial sum and a bit-serial modular reducer.
module pmm_cell
    import pmm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  pmm_cell_ctl_t       ctl,
    input  logic                en,
    input  logic                tap_we,
    input  logic [COEF_W-1:0]   coef,
    input  logic [COEF_W-1:0]   modulus,
    input  logic [COEF_W-1:0]   nbr_sum,
    output logic [COEF_W-1:0]   sum
);

    logic [COEF_W-1:0]   tap_reg;
    logic [COEF_W-1:0]   sum_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [COEF_W-1:0]   rem_reg;
    logic [2*COEF_W-1:0] mul_full;
    logic [COEF_W:0]     rem_shift;
    logic [COEF_W:0]     rem_sub;
    logic [COEF_W-1:0]   rem_next;

    assign sum = sum_reg;

    // Full-width product of the tap and the incoming coefficient.
    assign mul_full = tap_reg * coef;

    // One restoring step: bring in the next product bit, subtract the modulus if it fits.
    assign rem_shift = {rem_reg, prod_reg[PROD_W-1]};
    assign rem_sub   = rem_shift - {1'b0, modulus};
    assign rem_next  = (rem_shift >= {1'b0, modulus}) ? rem_sub[COEF_W-1:0]
                                                      : rem_shift[COEF_W-1:0];

    // Tap storage, written while the first polynomial loads.
    always_ff @(posedge aclk) begin
        if (tap_we) begin
            tap_reg <= coef;
        end
    end

    // Product and remainder registers of the reducer.
    always_ff @(posedge aclk) begin
        if (ctl.mul) begin
            prod_reg <= PROD_W'(mul_full) + PROD_W'(sum_reg);
            rem_reg  <= '0;
        end else if (ctl.red) begin
            prod_reg <= {prod_reg[PROD_W-2:0], 1'b0};
            rem_reg  <= rem_next;
        end
    end

    // Partial sum: cleared on reset or clear, shifted down the chain, or updated after reduction.
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            sum_reg <= '0;
        end else if (ctl.shift) begin
            sum_reg <= nbr_sum;
        end else if (ctl.commit && en) begin
            sum_reg <= rem_reg;
        end
    end

endmodule

[rtl/poly_mul_mod_prime.sv]
// Top level: sequencer, output register and the chain of multiply-reduce cells.
// A nonzero second-polynomial coefficient passes through multiply, 63 reduction steps,
// commit and emit before it reaches the output; a zero one goes straight to emit.
// Loads, clears and dropped coefficients are taken every cycle; a multiplied coefficient,
// an empty operand and a flush hold off the next input until their results are emitted.
// Reset is synchronous and active low: tap count, sums, overflow and modulus return to
// their initial values; taps stay undefined until loaded.
module poly_mul_mod_prime
    import pmm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [COEF_W-1:0]   cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_operation,
    input  logic [COEF_W-1:0]   s_coefficient,
    input  logic                s_last,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COEF_W-1:0]   m_product_coefficient,
    output logic [DEG_W-1:0]    m_degree_index,
    output logic                m_last_of_run,
    output logic                m_zero_product,
    output logic                m_overflow
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_RED    = 3'd2;
    localparam logic [2:0] ST_COMMIT = 3'd3;
    localparam logic [2:0] ST_HEAD   = 3'd4;
    localparam logic [2:0] ST_FLUSH  = 3'd5;
    localparam logic [2:0] ST_MARK   = 3'd6;
    localparam logic [2:0] ST_ZERO   = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [COEF_W-1:0]  modulus_reg;
    logic [COEF_W-1:0]  eff_mod;
    logic [IDX_W-1:0]   tap_count_reg, tap_count_next;
    logic [IDX_W-1:0]   sidx_reg, sidx_next;
    logic               ovf_reg, ovf_next;
    logic [COEF_W-1:0]  coef_reg, coef_next;
    logic               last_reg, last_next;
    logic [RCNT_W-1:0]  rcnt_reg, rcnt_next;
    logic [IDX_W-1:0]   fidx_reg, fidx_next;

    logic               out_valid_reg, out_valid_next;
    logic [COEF_W-1:0]  out_coef_reg, out_coef_next;
    logic [DEG_W-1:0]   out_deg_reg, out_deg_next;
    logic               out_last_reg, out_last_next;
    logic               out_zero_reg, out_zero_next;
    logic               out_ovf_reg, out_ovf_next;

    logic               accept;
    logic               out_free;
    logic               load_out;
    logic               dropped;
    logic               tap_load;
    pmm_cell_ctl_t      ctl;
    logic [TERMS-1:0]   cell_en;
    logic [TERMS-1:0]   cell_tap_we;
    logic [COEF_W-1:0]  sums [TERMS];

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign eff_mod  = (modulus_reg == '0) ? COEF_W'(1) : modulus_reg;
    assign dropped  = (sidx_reg >= IDX_W'(TERMS));
    assign tap_load = accept && (s_operation == OP_LOAD) && (tap_count_reg < IDX_W'(TERMS));

    assign m_valid               = out_valid_reg;
    assign m_product_coefficient = out_coef_reg;
    assign m_degree_index        = out_deg_reg;
    assign m_last_of_run         = out_last_reg;
    assign m_zero_product        = out_zero_reg;
    assign m_overflow            = out_ovf_reg;

    // Modulus register, written whenever the write enable is high; it must only change
    // while no transaction is in flight.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= {COEF_W{1'b1}};
        end else if (cfg_wr_en) begin
            modulus_reg <= cfg_wr_data;
        end
    end

    // Sequencer: decodes the transaction and steps the cells and the output register.
    always_comb begin
        state_next     = state_reg;
        tap_count_next = tap_count_reg;
        sidx_next      = sidx_reg;
        ovf_next       = ovf_reg;
        coef_next      = coef_reg;
        last_next      = last_reg;
        rcnt_next      = rcnt_reg;
        fidx_next      = fidx_reg;
        ctl            = '0;
        load_out       = 1'b0;
        out_coef_next  = out_coef_reg;
        out_deg_next   = out_deg_reg;
        out_last_next  = out_last_reg;
        out_zero_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    coef_next = s_coefficient;
                    last_next = s_last;
                    unique case (s_operation)
                        OP_LOAD: begin
                            if (tap_count_reg < IDX_W'(TERMS)) begin
                                tap_count_next = tap_count_reg + IDX_W'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            tap_count_next = '0;
                            ovf_next       = 1'b0;
                            sidx_next      = '0;
                            ctl.clear      = 1'b1;
                        end
                        default: begin
                            if (s_operation == OP_EMPTY || tap_count_reg == '0) begin
                                // Empty operand: abort the run; report a zero product if it is empty or last.
                                sidx_next = '0;
                                ctl.clear = 1'b1;
                                if (s_operation == OP_EMPTY || s_last) begin
                                    state_next = ST_ZERO;
                                end
                            end else if (dropped) begin
                                // Second polynomial too long: drop, possibly flush.
                                ovf_next = 1'b1;
                                if (s_last) begin
                                    fidx_next  = '0;
                                    state_next = (tap_count_reg == IDX_W'(1)) ? ST_MARK
                                                                              : ST_FLUSH;
                                end
                            end else if (s_coefficient != '0) begin
                                state_next = ST_MUL;
                            end else begin
                                state_next = ST_HEAD;
                            end
                        end
                    endcase
                end
            end
            ST_MUL: begin
                ctl.mul    = 1'b1;
                rcnt_next  = '0;
                state_next = ST_RED;
            end
            ST_RED: begin
                ctl.red   = 1'b1;
                rcnt_next = rcnt_reg + RCNT_W'(1);
                if (rcnt_reg == RCNT_W'(PROD_W - 1)) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                ctl.commit = 1'b1;
                state_next = ST_HEAD;
            end
            ST_HEAD: begin
                if (out_free) begin
                    load_out      = 1'b1;
                    out_coef_next = sums[0];
                    out_deg_next  = DEG_W'(sidx_reg);
                    out_last_next = last_reg && (tap_count_reg == IDX_W'(1));
                    ctl.shift     = 1'b1;
                    sidx_next     = sidx_reg + IDX_W'(1);
                    fidx_next     = '0;
                    if (!last_reg) begin
                        state_next = ST_IDLE;
                    end else if (tap_count_reg == IDX_W'(1)) begin
                        ctl.clear  = 1'b1;
                        sidx_next  = '0;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    load_out      = 1'b1;
                    out_coef_next = sums[0];
                    out_deg_next  = DEG_W'(sidx_reg + fidx_reg);
                    out_last_next = (fidx_reg == tap_count_reg - IDX_W'(2));
                    ctl.shift     = 1'b1;
                    fidx_next     = fidx_reg + IDX_W'(1);
                    if (out_last_next) begin
                        ctl.clear  = 1'b1;
                        sidx_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MARK: begin
                if (out_free) begin
                    load_out      = 1'b1;
                    out_coef_next = '0;
                    out_deg_next  = DEG_W'(sidx_reg);
                    out_last_next = 1'b1;
                    ctl.clear     = 1'b1;
                    sidx_next     = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                if (out_free) begin
                    load_out      = 1'b1;
                    out_coef_next = '0;
                    out_deg_next  = '0;
                    out_last_next = 1'b1;
                    out_zero_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
        endcase
        out_ovf_next   = ovf_reg;
        out_valid_next = load_out ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tap_count_reg <= '0;
            sidx_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tap_count_reg <= tap_count_next;
            sidx_reg      <= sidx_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge aclk) begin
        coef_reg <= coef_next;
        last_reg <= last_next;
        rcnt_reg <= rcnt_next;
        fidx_reg <= fidx_next;
        if (load_out) begin
            out_coef_reg <= out_coef_next;
            out_deg_reg  <= out_deg_next;
            out_last_reg <= out_last_next;
            out_zero_reg <= out_zero_next;
            out_ovf_reg  <= out_ovf_next;
        end
    end

    // The chain of cells; each shifts its sum to the neighbour below.
    for (genvar g = 0; g < TERMS; g++) begin : g_cell
        logic [COEF_W-1:0] nbr;
        assign cell_en[g]     = (IDX_W'(g) < tap_count_reg);
        assign cell_tap_we[g] = tap_load && (tap_count_reg == IDX_W'(g));
        if (g == TERMS - 1) begin : g_end
            assign nbr = '0;
        end else begin : g_mid
            assign nbr = sums[g + 1];
        end
        pmm_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .en      (cell_en[g]),
            .tap_we  (cell_tap_we[g]),
            .coef    (ctl.mul ? coef_reg : s_coefficient),
            .modulus (eff_mod),
            .nbr_sum (nbr),
            .sum     (sums[g])
        );
    end

`ifndef SYNTH
    // The tap count never exceeds the chain length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        tap_count_reg <= IDX_W'(TERMS))
        else $error("tap count beyond chain length");

    // A flush only runs with at least two taps loaded.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FLUSH |-> tap_count_reg >= IDX_W'(2))
        else $error("flush with fewer than two taps");

    // A zero-product result is always degree zero and ends its run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_product |-> m_degree_index == '0 && m_last_of_run)
        else $error("malformed zero-product result");

    // The reducer always runs its full count before the commit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COMMIT |-> $past(rcnt_reg) == RCNT_W'(PROD_W - 1))
        else $error("commit before reduction finished");
`endif

endmodule

[verif/poly_mul_mod_prime_checker.sv]
// Checker that predicts the product coefficients and compares every result transaction.
module poly_mul_mod_prime_checker
    import pmm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [COEF_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [1:0]        s_operation,
    input  logic [COEF_W-1:0] s_coefficient,
    input  logic              s_last,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [COEF_W-1:0] m_product_coefficient,
    input  logic [DEG_W-1:0]  m_degree_index,
    input  logic              m_last_of_run,
    input  logic              m_zero_product,
    input  logic              m_overflow,
    output int                fail_count,
    output int                pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic [DEG_W-1:0]  degree;
        logic              last_of_run;
        logic              zero_product;
        logic              overflow;
    } product_term_t;

    // Shadow copy of the multiplier state.
    logic [COEF_W-1:0] modulus_shadow;
    logic [COEF_W-1:0] tap_store [TERMS];
    int unsigned       tap_total;
    logic [COEF_W-1:0] sums [TERMS];
    int unsigned       stream_pos;
    logic              overflow_flag;

    product_term_t     awaited_terms[$];

    assign pending_count = awaited_terms.size();

    // Queue one expected product term, tagging it with the current overflow flag.
    function automatic void push_term(logic [COEF_W-1:0] c, int unsigned deg,
                                      logic lr, logic zp);
        product_term_t t;
        t.coef         = c;
        t.degree       = deg[DEG_W-1:0];
        t.last_of_run  = lr;
        t.zero_product = zp;
        t.overflow     = overflow_flag;
        awaited_terms.push_back(t);
    endfunction

    function automatic void drop_run();
        for (int j = 0; j < TERMS; j++) sums[j] = '0;
        stream_pos = 0;
    endfunction

    // Advance the shadow state by one input transaction and queue its product terms.
    function automatic void predict_product(logic [1:0] op, logic [COEF_W-1:0] coef,
                                            logic is_last);
        longint unsigned m;
        longint unsigned acc;
        int unsigned     n;
        logic            dropped;
        m = (modulus_shadow == 0) ? 64'd1 : 64'(modulus_shadow);
        n = tap_total;
        if (op == OP_LOAD) begin
            if (tap_total < TERMS) begin
                tap_store[tap_total] = coef;
                tap_total++;
            end else begin
                overflow_flag = 1'b1;
            end
            return;
        end
        if (op == OP_CLEAR) begin
            tap_total     = 0;
            overflow_flag = 1'b0;
            drop_run();
            return;
        end
        if (op == OP_EMPTY || n == 0) begin
            drop_run();
            if (op == OP_EMPTY || is_last) push_term('0, 0, 1'b1, 1'b1);
            return;
        end
        // A second-polynomial coefficient against a loaded first polynomial.
        dropped = (stream_pos >= TERMS);
        if (dropped) begin
            overflow_flag = 1'b1;
        end else begin
            if (coef != 0) begin
                for (int j = 0; j < n; j++) begin
                    acc     = 64'(tap_store[j]) * 64'(coef) + 64'(sums[j]);
                    sums[j] = COEF_W'(acc % m);
                end
            end
            push_term(sums[0], stream_pos, is_last && n == 1, 1'b0);
            for (int j = 0; j + 1 < n; j++) sums[j] = sums[j+1];
            sums[n-1] = '0;
            stream_pos++;
        end
        if (!is_last) return;
        // Flush the window of partial sums at the end of the run.
        if (n == 1) begin
            if (dropped) push_term('0, stream_pos, 1'b1, 1'b0);
        end else begin
            for (int j = 0; j + 1 < n; j++)
                push_term(sums[j], stream_pos + j, (j + 2) == n, 1'b0);
        end
        drop_run();
    endfunction

    // Watch both channels and the register port on every rising edge.
    always @(posedge aclk) begin
        product_term_t got;
        product_term_t want;
        if (!aresetn) begin
            modulus_shadow = {COEF_W{1'b1}};
            tap_total      = 0;
            overflow_flag  = 1'b0;
            drop_run();
            awaited_terms.delete();
            fail_count     = 0;
        end else begin
            if (cfg_wr_en) modulus_shadow = cfg_wr_data;
            if (m_valid && m_ready) begin
                got = '{m_product_coefficient, m_degree_index, m_last_of_run,
                        m_zero_product, m_overflow};
                if (awaited_terms.size() == 0) begin
                    $display("%0t: unexpected result transaction %p", $time, got);
                    fail_count++;
                end else begin
                    want = awaited_terms.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) predict_product(s_operation, s_coefficient, s_last);
        end
    end

endmodule

[verif/poly_mul_mod_prime_test.sv]
// Testbench top: clock, reset, stimulus with idling phases, watchdog and verdict.
module poly_mul_mod_prime_test
    import pmm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 5000;
    localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1);

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [COEF_W-1:0] cfg_wr_data   = '0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [1:0]        s_operation   = OP_LOAD;
    logic [COEF_W-1:0] s_coefficient = '0;
    logic              s_last        = 1'b0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [COEF_W-1:0] m_product_coefficient;
    logic [DEG_W-1:0]  m_degree_index;
    logic              m_last_of_run;
    logic              m_zero_product;
    logic              m_overflow;

    int                fail_count;
    int                pending_count;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                items_sent = 0;
    int                quiet_cycles = 0;
    logic [COEF_W-1:0] cur_modulus = COEF_MAX;

    poly_mul_mod_prime DUT (.*);

    poly_mul_mod_prime_checker product_check (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver stalls at random according to the current phase.
    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: ends the run if no transaction moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("poly_mul_mod_prime_test: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one input transaction and hold it until it is accepted.
    task automatic send_item(logic [1:0] op, logic [COEF_W-1:0] coef, logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_coefficient <= coef;
        s_last        <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Wait for the block to drain, then write the modulus.
    task automatic set_modulus(logic [COEF_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_modulus = value;
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(9))
            0:       return '0;
            1:       return COEF_MAX;
            2:       return cur_modulus - COEF_ONE;
            3:       return cur_modulus;
            4, 5:    return COEF_W'($urandom_range(cur_modulus - 1));
            default: return COEF_W'($urandom());
        endcase
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 5) return 0;
        if (r < 80) return $urandom_range(1, 6);
        if (r < 92) return $urandom_range(7, 31);
        return $urandom_range(32, 34);
    endfunction

    // One multiplication run, occasionally broken, or a burst of noise.
    task automatic run_sequence();
        int ntaps;
        int nsec;
        int kind;
        kind = $urandom_range(99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 4))
                send_item(2'($urandom_range(3)), COEF_W'($urandom()), 1'($urandom()));
            return;
        end
        ntaps = pick_len();
        nsec  = pick_len();
        if ($urandom_range(99) < 85) send_item(OP_CLEAR, COEF_W'($urandom()), 1'($urandom()));
        for (int i = 0; i < ntaps; i++) send_item(OP_LOAD, pick_coef(), 1'($urandom()));
        for (int i = 0; i < nsec; i++) begin
            if (kind < 14 && i == nsec / 2)
                send_item(OP_EMPTY, pick_coef(), 1'($urandom()));
            else
                send_item(OP_MUL, pick_coef(), (i == nsec - 1) && kind >= 18);
        end
    endtask

    initial begin
        logic [COEF_W-1:0] moduli [8];
        moduli = '{COEF_MAX, 31'd2, 31'd65521, COEF_MAX - COEF_ONE, 31'd3,
                   31'd1000003, 31'd2147483629, 31'd7};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        set_modulus(COEF_MAX);

        // Directed: field extremes, every operation and the special cases.
        send_item(OP_MUL, 31'd5, 1'b0);
        send_item(OP_MUL, 31'd5, 1'b1);
        send_item(OP_EMPTY, COEF_MAX, 1'b1);
        send_item(OP_LOAD, COEF_MAX, 1'b0);
        send_item(OP_LOAD, COEF_MAX - COEF_ONE, 1'b1);
        send_item(OP_LOAD, 31'd1, 1'b0);
        send_item(OP_MUL, COEF_MAX - COEF_ONE, 1'b0);
        send_item(OP_MUL, '0, 1'b0);
        send_item(OP_MUL, COEF_MAX, 1'b0);
        send_item(OP_MUL, 31'h2AAAAAAA, 1'b1);
        send_item(OP_MUL, 31'h55555555, 1'b0);
        send_item(OP_EMPTY, '0, 1'b0);
        send_item(OP_CLEAR, '0, 1'b0);
        send_item(OP_LOAD, 31'd3, 1'b0);
        send_item(OP_MUL, 31'd4, 1'b1);
        send_item(OP_CLEAR, COEF_MAX, 1'b1);
        send_item(OP_LOAD, COEF_MAX - COEF_ONE, 1'b0);
        send_item(OP_LOAD, COEF_MAX - COEF_ONE, 1'b0);
        send_item(OP_MUL, COEF_MAX - COEF_ONE, 1'b1);
        send_item(OP_CLEAR, '0, 1'b0);

        // Random phases, each with its own modulus and idling pattern.
        for (int phase = 0; phase < 8; phase++) begin
            set_modulus(moduli[phase]);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            while (items_sent < 20 + (phase + 1) * 56) run_sequence();
        end

        // Close the last run so that every pending sum is flushed.
        send_item(OP_EMPTY, '0, 1'b1);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        if (fail_count == 0)
            $display("poly_mul_mod_prime_test: PASS");
        else
            $display("poly_mul_mod_prime_test: FAIL");
        $finish;
    end

endmodule
